// ===== src/sfp_pkg.sv =====
package sfp_pkg;

    localparam int unsigned FRAME_LEN    = 15;
    localparam int unsigned PAYLOAD_LEN  = 12;
    localparam int unsigned SAMPLE_W     = 12;
    localparam int unsigned SAMPLE_COUNT = 8;

    localparam logic [7:0] HDR_FIRST     = 8'h55;
    localparam logic [7:0] HDR_SECOND    = 8'hAA;
    localparam logic [7:0] SCRAMBLE_MASK = 8'h55;

    localparam logic [3:0] POS_HDR_FIRST  = 4'd0;
    localparam logic [3:0] POS_HDR_SECOND = 4'd1;
    localparam logic [3:0] POS_PAYLOAD    = 4'd2;
    localparam logic [3:0] POS_CHECK      = 4'd14;

    typedef logic [3:0] t_pos;

    typedef struct packed {
        logic [PAYLOAD_LEN-1:0][7:0] payload;
        logic [7:0]                  check;
    } t_frame;

    // Nibble swap, then the even bits are inverted.
    function automatic logic [7:0] scramble(input logic [7:0] b);
        return {b[3:0], b[7:4]} ^ SCRAMBLE_MASK;
    endfunction

endpackage

// ===== src/sfp_front.sv =====
module sfp_front import sfp_pkg::*; (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [SAMPLE_COUNT-1:0][SAMPLE_W-1:0] i_samples,
    output logic                              o_valid,
    input  logic                              i_ready,
    output t_frame                            o_frame
);

    logic   r_valid;
    t_frame r_frame;
    t_frame n_frame;
    logic [3:0][7:0] pair_sum;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_frame = r_frame;

    // Each pair of samples fills three bytes; the check byte is summed per pair first.
    always_comb begin
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        for (int p = 0; p < 4; p++) begin
            a = i_samples[2*p];
            b = i_samples[2*p+1];
            n_frame.payload[3*p]   = a[11:4];
            n_frame.payload[3*p+1] = {a[3:0], b[11:8]};
            n_frame.payload[3*p+2] = b[7:0];
            pair_sum[p] = a[11:4] + {a[3:0], b[11:8]} + b[7:0];
        end
        n_frame.check = (pair_sum[0] + pair_sum[1]) + (pair_sum[2] + pair_sum[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_frame <= n_frame;
        end
    end

endmodule

// ===== src/sfp_queue.sv =====
module sfp_queue import sfp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_frame i_frame,
    output logic   o_valid,
    input  logic   i_pop,
    output t_frame o_frame
);

    localparam int unsigned DEPTH = 2;

    t_frame     r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_frame = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

// ===== src/sfp_back.sv =====
module sfp_back import sfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_frame     i_frame,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_frame_byte,
    output logic       o_last_byte
);

    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_last;
    t_pos       r_pos;
    logic       advance;
    logic [7:0] plain;
    t_pos       payload_idx;

    assign advance     = (!r_out_valid || i_ready) && i_valid;
    assign o_pop       = advance && (r_pos == POS_CHECK);
    assign o_valid     = r_out_valid;
    assign o_frame_byte = r_byte;
    assign o_last_byte = r_last;
    assign payload_idx = r_pos - POS_PAYLOAD;

    always_comb begin
        case (r_pos)
            POS_HDR_FIRST:  plain = HDR_FIRST;
            POS_HDR_SECOND: plain = HDR_SECOND;
            POS_CHECK:      plain = i_frame.check;
            default:        plain = i_frame.payload[payload_idx];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= POS_HDR_FIRST;
        end else begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= i_valid;
            end
            if (advance) begin
                r_pos <= (r_pos == POS_CHECK) ? POS_HDR_FIRST : r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= scramble(plain);
            r_last <= (r_pos == POS_CHECK);
        end
    end

endmodule

// ===== src/sample_frame_packer.sv =====
// After a sample set is transferred, its frame passes the front register, the queue and
// the output register in turn. Throughput: one byte per cycle while not stalled, set
// by the single byte-wide output register that walks each frame from byte 0 to byte 14.
// A two-entry frame queue lets the input take further sets while a frame is sent.
// Reset is synchronous and active low; it empties all stages and drops o_valid.
module sample_frame_packer import sfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_sample_zero,
    input  logic [11:0] i_sample_one,
    input  logic [11:0] i_sample_two,
    input  logic [11:0] i_sample_three,
    input  logic [11:0] i_sample_four,
    input  logic [11:0] i_sample_five,
    input  logic [11:0] i_sample_six,
    input  logic [11:0] i_sample_seven,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);

    logic [SAMPLE_COUNT-1:0][SAMPLE_W-1:0] samples;
    logic   front_valid;
    logic   queue_ready;
    t_frame front_frame;
    logic   queue_valid;
    logic   back_pop;
    t_frame queue_frame;

    assign samples = {i_sample_seven, i_sample_six, i_sample_five, i_sample_four,
                      i_sample_three, i_sample_two, i_sample_one, i_sample_zero};

    sfp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_samples (samples),
        .o_valid   (front_valid),
        .i_ready   (queue_ready),
        .o_frame   (front_frame)
    );

    sfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (queue_ready),
        .i_frame (front_frame),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_frame (queue_frame)
    );

    sfp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .i_frame      (queue_frame),
        .o_pop        (back_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule

// ===== src/sfp_checker.sv =====
module sfp_checker import sfp_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_ready,
    input logic [7:0] i_frame_byte,
    input logic       i_last_byte
);

    t_pos r_seen;

    // Counts the bytes transferred so far within the current frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= POS_HDR_FIRST;
        end else if (i_out_valid && i_ready) begin
            r_seen <= (r_seen == POS_CHECK) ? POS_HDR_FIRST : r_seen + 4'd1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ready |=>
            i_out_valid && $stable(i_frame_byte) && $stable(i_last_byte))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid straight after reset");

    a_last_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_byte == (r_seen == POS_CHECK)))
        else $error("last-byte flag out of place");

    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (r_seen == POS_HDR_FIRST || r_seen == POS_HDR_SECOND) |->
            i_frame_byte == ((r_seen == POS_HDR_FIRST) ? scramble(HDR_FIRST)
                                                        : scramble(HDR_SECOND)))
        else $error("frame header wrong");

endmodule

bind sample_frame_packer sfp_checker u_sfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_valid),
    .i_ready      (i_ready),
    .i_frame_byte (o_frame_byte),
    .i_last_byte  (o_last_byte)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sfp_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int NUM_DIRECTED    = 16;

    typedef struct packed {
        logic [SAMPLE_COUNT-1:0][SAMPLE_W-1:0] ch;
        logic                                  sum_known;
        logic [7:0]                            sum_byte;
    } t_directed_row;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [11:0] i_sample_zero = '0;
    logic [11:0] i_sample_one = '0;
    logic [11:0] i_sample_two = '0;
    logic [11:0] i_sample_three = '0;
    logic [11:0] i_sample_four = '0;
    logic [11:0] i_sample_five = '0;
    logic [11:0] i_sample_six = '0;
    logic [11:0] i_sample_seven = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_frame_byte;
    logic        o_last_byte;

    t_frame_byte   pending_frame_bytes[$];
    t_frame_byte   head;
    t_directed_row directed_rows [NUM_DIRECTED];
    int            mismatch_count = 0;
    int            bytes_seen = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_off_req = 1'b0;

    sample_frame_packer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_zero  (i_sample_zero),
        .i_sample_one   (i_sample_one),
        .i_sample_two   (i_sample_two),
        .i_sample_three (i_sample_three),
        .i_sample_four  (i_sample_four),
        .i_sample_five  (i_sample_five),
        .i_sample_six   (i_sample_six),
        .i_sample_seven (i_sample_seven),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_byte   (o_frame_byte),
        .o_last_byte    (o_last_byte)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s at frame byte %0d: got %02h, want %02h",
                 $time, what, bytes_seen % FRAME_LEN, got, want);
        mismatch_count++;
    endtask

    // Builds the plain frame, sums the payload and scrambles it; a known check byte wins.
    function automatic void pack_and_scramble(input logic [SAMPLE_COUNT-1:0][SAMPLE_W-1:0] ch,
                                              input logic sum_known,
                                              input logic [7:0] sum_byte);
        logic [7:0]  plain [FRAME_LEN];
        logic [7:0]  sum;
        t_frame_byte entry;
        int          p;
        int          k;
        plain[POS_HDR_FIRST]  = HDR_FIRST;
        plain[POS_HDR_SECOND] = HDR_SECOND;
        for (p = 0; p < 4; p++) begin
            plain[POS_PAYLOAD + 3*p]     = ch[2*p][11:4];
            plain[POS_PAYLOAD + 3*p + 1] = {ch[2*p][3:0], ch[2*p+1][11:8]};
            plain[POS_PAYLOAD + 3*p + 2] = ch[2*p+1][7:0];
        end
        sum = 8'h00;
        for (k = POS_PAYLOAD; k < POS_CHECK; k++) begin
            sum = sum + plain[k];
        end
        plain[POS_CHECK] = sum;
        for (k = 0; k < FRAME_LEN; k++) begin
            entry.frame_byte = {plain[k][3:0], plain[k][7:4]} ^ SCRAMBLE_MASK;
            entry.last_byte  = (k == POS_CHECK);
            if (k == POS_CHECK && sum_known) begin
                entry.frame_byte = sum_byte;
            end
            pending_frame_bytes.push_back(entry);
        end
    endfunction

    // Called just after the clock rises; valid only drops when a gap is actually taken.
    task automatic offer_set(input logic [SAMPLE_COUNT-1:0][SAMPLE_W-1:0] ch,
                             input logic sum_known, input logic [7:0] sum_byte);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_zero  <= ch[0];
        i_sample_one   <= ch[1];
        i_sample_two   <= ch[2];
        i_sample_three <= ch[3];
        i_sample_four  <= ch[4];
        i_sample_five  <= ch[5];
        i_sample_six   <= ch[6];
        i_sample_seven <= ch[7];
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pack_and_scramble(ch, sum_known, sum_byte);
    endtask

    function automatic logic [11:0] pick_sample();
        case ($urandom_range(7))
            0: return 12'h000;
            1: return 12'hFFF;
            2: return 12'h001 << $urandom_range(11);
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    task automatic run_random_sets(input int count);
        logic [SAMPLE_COUNT-1:0][SAMPLE_W-1:0] ch;
        int c;
        repeat (count) begin
            for (c = 0; c < SAMPLE_COUNT; c++) begin
                ch[c] = pick_sample();
            end
            offer_set(ch, 1'b0, 8'h00);
        end
    endtask

    // The receiver side: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_frame_bytes.size() == 0) begin
                report_mismatch("unexpected transfer", o_frame_byte, 8'h00);
            end else begin
                head = pending_frame_bytes.pop_front();
                if (o_frame_byte !== head.frame_byte) begin
                    report_mismatch("frame byte", o_frame_byte, head.frame_byte);
                end
                if (o_last_byte !== head.last_byte) begin
                    report_mismatch("last-byte flag", 8'(o_last_byte), 8'(head.last_byte));
                end
            end
            bytes_seen++;
        end
    end

    initial begin : stimulus
        int r;
        // Channels are listed from seven down to zero. A known check byte is given
        // already scrambled: all zero, all ones (the sum wraps) and the two checkerboards.
        directed_rows = '{
            {12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
             1'b1, 8'h55},
            {12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
             1'b1, 8'h1A},
            {12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA,
             1'b1, 8'h5C},
            {12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555,
             1'b1, 8'h13},
            {12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'hFFF,
             1'b0, 8'h00},
            {12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'hFFF, 12'h000,
             1'b0, 8'h00},
            {12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'hFFF, 12'h000, 12'h000,
             1'b0, 8'h00},
            {12'h000, 12'h000, 12'h000, 12'h000, 12'hFFF, 12'h000, 12'h000, 12'h000,
             1'b0, 8'h00},
            {12'h000, 12'h000, 12'h000, 12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000,
             1'b0, 8'h00},
            {12'h000, 12'h000, 12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
             1'b0, 8'h00},
            {12'h000, 12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
             1'b0, 8'h00},
            {12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
             1'b0, 8'h00},
            {12'h001, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001,
             1'b0, 8'h00},
            {12'h800, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800,
             1'b0, 8'h00},
            {12'h678, 12'h345, 12'h012, 12'hDEF, 12'hABC, 12'h789, 12'h456, 12'h123,
             1'b0, 8'h00},
            {12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
             1'b1, 8'h55}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_DIRECTED; r++) begin
            offer_set(directed_rows[r].ch, directed_rows[r].sum_known,
                      directed_rows[r].sum_byte);
        end

        run_random_sets(100);

        send_idle_pct = 53;
        run_random_sets(90);

        send_idle_pct  = 0;
        recv_stall_pct = 53;
        run_random_sets(90);

        send_idle_pct  = 10;
        recv_stall_pct = 10;
        run_random_sets(90);

        // The output is held back for a long stretch while sets keep coming, so the
        // frame queue fills and the input has to stall.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        run_random_sets(40);

        recv_stall_pct = 30;
        send_idle_pct  = 30;
        run_random_sets(50);

        i_valid <= 1'b0;
        while (pending_frame_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
